@@ rtl/pge_pkg.sv @@
// pge_pkg: shared constants, command and state codes, cell address helper
// and the distance table for the pheromone grid engine.
// No dependencies; used by pheromone_grid_engine_core.
package pge_pkg;

    // Grid geometry
    localparam int GRID_W     = 64;
    localparam int GRID_H     = 64;
    localparam int MAX_RADIUS = 15;

    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);

    // Signed working width for coordinates around the grid
    localparam int CW = 10;

    // Radius, squared distance and Q4.16 distance widths
    localparam int R_W  = $clog2(MAX_RADIUS + 1);
    localparam int QW   = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
    localparam int QSW  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int DT_N = MAX_RADIUS * MAX_RADIUS + 1;
    localparam int DW   = R_W + 16;

    // Cell value, deposit product and divider widths
    localparam int VW  = 32;
    localparam int PW  = VW + DW;
    localparam int NW  = PW - 16;
    localparam int DCW = $clog2(NW);

    // Decay factor one in Q1.16
    localparam logic [16:0] DECAY_ONE = 17'h1_0000;

    // Result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Register byte address
    localparam logic [1:0] REG_DECAY_RATE = 2'd0;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_DECAY     = 3'd1,
        CMD_DEPOSIT   = 3'd2,
        CMD_READ      = 3'd3,
        CMD_STRONGEST = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_DEC,
        ST_DEP_SCAN,
        ST_DEP_MUL,
        ST_DEP_DIV,
        ST_DEP_WR,
        ST_RD_WAIT,
        ST_SRCH,
        ST_SRCH_TAIL,
        ST_FIN
    } state_t;

    typedef logic [DW-1:0] dist_tab_t [DT_N];

    // Row-major cell address
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                    input logic [YW-1:0] y);
        return ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x);
    endfunction

    // floor(sqrt(q * 2^32)) for every squared distance inside the largest disc
    function automatic dist_tab_t build_dist_tab();
        dist_tab_t       t;
        longint unsigned n;
        longint unsigned res;
        longint unsigned b;
        for (int q = 0; q < DT_N; q++)
        begin
            n   = longint'(q) << 32;
            res = 0;
            b   = 64'h4000_0000_0000_0000;
            while (b > n)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            t[q] = DW'(res);
        end
        return t;
    endfunction

    localparam dist_tab_t DIST_TAB = build_dist_tab();

endpackage

@@ rtl/pge_ram.sv @@
// pge_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pheromone_grid_engine_core.sv @@
// pheromone_grid_engine_core: top level of the pheromone grid engine.
// Depends on pge_pkg and pge_ram (grid store).
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | in_valid / in_ready    | cmd, pos_x, pos_y, radius, amount, tick_count
//  result   | out_valid / out_ready  | status, value, best_x, best_y
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (decay_rate)
//
// Clear sweeps all DEPTH cells, decay too when tick_count is nonzero; read returns
// one cell; strongest scans up to (2r)^2 cells; deposit visits up to (2r+1)^2
// cells and divides the share of each cell in the disc by a nonzero r in a bit-serial
// divider. All share the single grid RAM port pair; in_ready rises in the cycle after the result is handed over.
// After reset a clearing pass over all DEPTH (4096) cells runs before in_ready rises.
// A finished result waits in the output register; a new command is taken
// meanwhile, and a later result waits in ST_FIN until the register is free.
module pheromone_grid_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic signed [8:0] pos_x,
    input  logic signed [8:0] pos_y,
    input  logic [3:0]  radius,
    input  logic [31:0] amount,
    input  logic [15:0] tick_count,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [31:0] value,
    output logic [7:0]  best_x,
    output logic [7:0]  best_y,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW  = pge_pkg::CW;
    localparam int AW  = pge_pkg::ADDR_W;
    localparam int XW  = pge_pkg::XW;
    localparam int YW  = pge_pkg::YW;
    localparam int R_W = pge_pkg::R_W;
    localparam int VW  = pge_pkg::VW;
    localparam int NW  = pge_pkg::NW;
    localparam int DW  = pge_pkg::DW;
    localparam int PW  = pge_pkg::PW;
    localparam int QW  = pge_pkg::QW;
    localparam int QSW = pge_pkg::QSW;
    localparam int DCW = pge_pkg::DCW;

    // Control registers
    pge_pkg::state_t       state_reg, state_next;
    logic [15:0]           decay_rate_reg, decay_rate_next;
    logic                  out_valid_reg, out_valid_next;
    logic [AW:0]           k_reg, k_next;
    logic                  d1_v_reg, d1_v_next;
    logic                  d2_v_reg, d2_v_next;
    logic                  s_v_reg, s_v_next;
    logic                  found_reg, found_next;

    // Payload registers
    logic signed [CW-1:0]  px_reg, px_next;
    logic signed [CW-1:0]  py_reg, py_next;
    logic [R_W-1:0]        r_reg, r_next;
    logic [VW-1:0]         amount_reg, amount_next;
    logic signed [CW-1:0]  cx_reg, cx_next;
    logic signed [CW-1:0]  cy_reg, cy_next;
    logic signed [CW-1:0]  xlo_reg, xlo_next;
    logic signed [CW-1:0]  xhi_reg, xhi_next;
    logic signed [CW-1:0]  ylo_reg, ylo_next;
    logic signed [CW-1:0]  yhi_reg, yhi_next;
    logic [AW-1:0]         d1_a_reg, d1_a_next;
    logic [AW-1:0]         d2_a_reg, d2_a_next;
    logic [VW+16:0]        dprod_reg, dprod_next;
    logic [DW-1:0]         frac_reg, frac_next;
    logic [VW-1:0]         cell_reg, cell_next;
    logic [NW-1:0]         div_n_reg, div_n_next;
    logic [R_W-1:0]        rem_reg, rem_next;
    logic [NW-1:0]         quo_reg, quo_next;
    logic [DCW-1:0]        dcnt_reg, dcnt_next;
    logic [XW-1:0]         s_x_reg, s_x_next;
    logic [YW-1:0]         s_y_reg, s_y_next;
    logic [VW-1:0]         best_reg, best_next;
    logic [XW-1:0]         bx_reg, bx_next;
    logic [YW-1:0]         by_reg, by_next;
    logic                  res_status_reg, res_status_next;
    logic [VW-1:0]         res_value_reg, res_value_next;
    logic [7:0]            res_bx_reg, res_bx_next;
    logic [7:0]            res_by_reg, res_by_next;
    logic                  status_reg, status_next;
    logic [VW-1:0]         value_reg, value_next;
    logic [7:0]            best_x_reg, best_x_next;
    logic [7:0]            best_y_reg, best_y_next;

    // RAM port signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [VW-1:0]         ram_rdata;

    // Command decode helpers
    logic signed [CW-1:0]  in_px, in_py, in_r;
    logic [R_W-1:0]        r_sat;
    logic                  in_on_grid;
    logic signed [CW-1:0]  lo_x, lo_y, hd_x, hd_y, hs_x, hs_y;
    logic signed [CW-1:0]  gw_m1, gh_m1, one_c;

    // Scan helpers
    logic                  scan_last;
    logic signed [CW-1:0]  dx, dy;
    logic [R_W-1:0]        dxa, dya;
    logic [QSW-1:0]        qd, rsq;
    logic                  in_disc;
    logic [QW-1:0]         dt_idx;
    logic [R_W:0]          trial;
    logic                  trial_ge;
    logic [VW:0]           sat_sum;
    logic [VW-1:0]         dec_n;
    logic                  take_best;
    logic                  cfg_sel;
    logic                  cfg_wr;

    pge_ram #(
        .WIDTH (VW),
        .DEPTH (pge_pkg::DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr == pge_pkg::REG_DECAY_RATE);
    assign prdata  = cfg_sel ? 32'(decay_rate_reg) : '0;
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;

    // Command field decode and window clipping
    assign in_px  = CW'(pos_x);
    assign in_py  = CW'(pos_y);
    assign r_sat  = (radius > pge_pkg::MAX_RADIUS) ? R_W'(pge_pkg::MAX_RADIUS)
                                                   : R_W'(radius);
    assign in_r   = signed'(CW'(r_sat));
    assign gw_m1  = signed'(CW'(pge_pkg::GRID_W - 1));
    assign gh_m1  = signed'(CW'(pge_pkg::GRID_H - 1));
    assign one_c  = signed'(CW'(1));
    assign in_on_grid = (in_px >= 0) && (in_py >= 0) && (in_px <= gw_m1) && (in_py <= gh_m1);

    assign lo_x = (in_px - in_r < 0) ? '0 : in_px - in_r;
    assign lo_y = (in_py - in_r < 0) ? '0 : in_py - in_r;
    assign hd_x = (in_px + in_r > gw_m1) ? gw_m1 : in_px + in_r;
    assign hd_y = (in_py + in_r > gh_m1) ? gh_m1 : in_py + in_r;
    assign hs_x = (in_px + in_r - one_c > gw_m1) ? gw_m1 : in_px + in_r - one_c;
    assign hs_y = (in_py + in_r - one_c > gh_m1) ? gh_m1 : in_py + in_r - one_c;

    // Disc test and distance lookup for the current deposit cell
    assign scan_last = (cx_reg == xhi_reg) && (cy_reg == yhi_reg);
    assign dx        = cx_reg - px_reg;
    assign dy        = cy_reg - py_reg;
    assign dxa       = dx[CW-1] ? R_W'(-dx) : R_W'(dx);
    assign dya       = dy[CW-1] ? R_W'(-dy) : R_W'(dy);
    assign qd        = QSW'(dxa) * QSW'(dxa) + QSW'(dya) * QSW'(dya);
    assign rsq       = QSW'(r_reg) * QSW'(r_reg);
    assign in_disc   = qd <= rsq;
    assign dt_idx    = in_disc ? qd[QW-1:0] : '0;

    // Divider step, saturating add, decay result
    assign trial     = {rem_reg, div_n_reg[NW-1]};
    assign trial_ge  = trial >= {1'b0, r_reg};
    assign sat_sum   = {1'b0, cell_reg} + {1'b0, quo_reg[VW-1:0]};
    assign dec_n     = dprod_reg[VW+15:16];
    assign take_best = s_v_reg && (!found_reg || ram_rdata > best_reg);

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        decay_rate_next = decay_rate_reg;
        out_valid_next  = out_valid_reg;
        k_next          = k_reg;
        d1_v_next       = 1'b0;
        d2_v_next       = 1'b0;
        s_v_next        = 1'b0;
        found_next      = found_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        r_next          = r_reg;
        amount_next     = amount_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        xlo_next        = xlo_reg;
        xhi_next        = xhi_reg;
        ylo_next        = ylo_reg;
        yhi_next        = yhi_reg;
        d1_a_next       = d1_a_reg;
        d2_a_next       = d2_a_reg;
        dprod_next      = dprod_reg;
        frac_next       = frac_reg;
        cell_next       = cell_reg;
        div_n_next      = div_n_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        s_x_next        = s_x_reg;
        s_y_next        = s_y_reg;
        best_next       = best_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_bx_next     = res_bx_reg;
        res_by_next     = res_by_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        ram_we          = 1'b0;
        ram_waddr       = k_reg[AW-1:0];
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = pge_pkg::cell_addr(cx_reg[XW-1:0], cy_reg[YW-1:0]);
        in_ready        = 1'b0;

        if (cfg_wr)
        begin
            decay_rate_next = pwdata[15:0];
        end

        // Result register drains independently of the command logic
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Clearing pass after reset and clear command
            pge_pkg::ST_INIT,
            pge_pkg::ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AW-1:0];
                ram_wdata = '0;
                k_next    = k_reg + 1'b1;
                if (k_reg == (AW+1)'(pge_pkg::DEPTH - 1))
                begin
                    state_next = (state_reg == pge_pkg::ST_INIT) ? pge_pkg::ST_IDLE
                                                                 : pge_pkg::ST_FIN;
                end
            end

            pge_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    px_next         = in_px;
                    py_next         = in_py;
                    r_next          = r_sat;
                    amount_next     = amount;
                    k_next          = '0;
                    found_next      = 1'b0;
                    res_status_next = pge_pkg::STAT_OK;
                    res_value_next  = '0;
                    res_bx_next     = '0;
                    res_by_next     = '0;
                    case (pge_pkg::cmd_t'(cmd))
                        pge_pkg::CMD_CLEAR:
                        begin
                            state_next = pge_pkg::ST_CLR;
                        end
                        pge_pkg::CMD_DECAY:
                        begin
                            state_next = (tick_count != '0) ? pge_pkg::ST_DEC
                                                            : pge_pkg::ST_FIN;
                        end
                        pge_pkg::CMD_DEPOSIT:
                        begin
                            cx_next  = lo_x;
                            cy_next  = lo_y;
                            xlo_next = lo_x;
                            ylo_next = lo_y;
                            xhi_next = hd_x;
                            yhi_next = hd_y;
                            if (in_on_grid)
                            begin
                                state_next = pge_pkg::ST_DEP_SCAN;
                            end
                            else
                            begin
                                res_status_next = pge_pkg::STAT_ERR;
                                state_next      = pge_pkg::ST_FIN;
                            end
                        end
                        pge_pkg::CMD_READ:
                        begin
                            ram_raddr = pge_pkg::cell_addr(in_px[XW-1:0], in_py[YW-1:0]);
                            if (in_on_grid)
                            begin
                                ram_re     = 1'b1;
                                state_next = pge_pkg::ST_RD_WAIT;
                            end
                            else
                            begin
                                res_status_next = pge_pkg::STAT_ERR;
                                state_next      = pge_pkg::ST_FIN;
                            end
                        end
                        pge_pkg::CMD_STRONGEST:
                        begin
                            cx_next  = lo_x;
                            cy_next  = lo_y;
                            xlo_next = lo_x;
                            ylo_next = lo_y;
                            xhi_next = hs_x;
                            yhi_next = hs_y;
                            if ((lo_x > hs_x) || (lo_y > hs_y))
                            begin
                                res_status_next = pge_pkg::STAT_ERR;
                                state_next      = pge_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = pge_pkg::ST_SRCH;
                            end
                        end
                        default:
                        begin
                            res_status_next = pge_pkg::STAT_ERR;
                            state_next      = pge_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            // Decay sweep: read each cell, multiply into dprod_reg, then write it back
            pge_pkg::ST_DEC:
            begin
                if (k_reg != (AW+1)'(pge_pkg::DEPTH))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = k_reg[AW-1:0];
                    d1_v_next = 1'b1;
                    d1_a_next = k_reg[AW-1:0];
                    k_next    = k_reg + 1'b1;
                end
                if (d1_v_reg)
                begin
                    dprod_next = (VW+17)'(ram_rdata)
                               * (VW+17)'(pge_pkg::DECAY_ONE - 17'(decay_rate_reg));
                    d2_v_next  = 1'b1;
                    d2_a_next  = d1_a_reg;
                end
                if (d2_v_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = d2_a_reg;
                    ram_wdata = ((36'(dec_n) * 36'(10)) < 36'(decay_rate_reg)) ? '0 : dec_n;
                end
                if ((k_reg == (AW+1)'(pge_pkg::DEPTH)) && !d1_v_reg && !d2_v_reg)
                begin
                    state_next = pge_pkg::ST_FIN;
                end
            end

            // Deposit: pick next cell inside the disc and read it
            pge_pkg::ST_DEP_SCAN:
            begin
                if (in_disc)
                begin
                    ram_re     = 1'b1;
                    frac_next  = (DW'(r_reg) << 16) - pge_pkg::DIST_TAB[dt_idx];
                    state_next = pge_pkg::ST_DEP_MUL;
                end
                else if (scan_last)
                begin
                    state_next = pge_pkg::ST_FIN;
                end
                else if (cy_reg == yhi_reg)
                begin
                    cy_next = ylo_reg;
                    cx_next = cx_reg + 1'b1;
                end
                else
                begin
                    cy_next = cy_reg + 1'b1;
                end
            end

            pge_pkg::ST_DEP_MUL:
            begin
                cell_next = ram_rdata;
                rem_next  = '0;
                dcnt_next = '0;
                if (r_reg == '0)
                begin
                    quo_next   = NW'(amount_reg);
                    state_next = pge_pkg::ST_DEP_WR;
                end
                else
                begin
                    div_n_next = NW'((PW'(amount_reg) * PW'(frac_reg)) >> 16);
                    state_next = pge_pkg::ST_DEP_DIV;
                end
            end

            // Restoring division by the radius, one quotient bit a cycle
            pge_pkg::ST_DEP_DIV:
            begin
                rem_next   = trial_ge ? R_W'(trial - {1'b0, r_reg}) : R_W'(trial);
                div_n_next = div_n_reg << 1;
                quo_next   = {quo_reg[NW-2:0], trial_ge};
                dcnt_next  = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    state_next = pge_pkg::ST_DEP_WR;
                end
            end

            pge_pkg::ST_DEP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = pge_pkg::cell_addr(cx_reg[XW-1:0], cy_reg[YW-1:0]);
                ram_wdata = sat_sum[VW] ? '1 : sat_sum[VW-1:0];
                if (scan_last)
                begin
                    state_next = pge_pkg::ST_FIN;
                end
                else
                begin
                    state_next = pge_pkg::ST_DEP_SCAN;
                    if (cy_reg == yhi_reg)
                    begin
                        cy_next = ylo_reg;
                        cx_next = cx_reg + 1'b1;
                    end
                    else
                    begin
                        cy_next = cy_reg + 1'b1;
                    end
                end
            end

            pge_pkg::ST_RD_WAIT:
            begin
                res_value_next = ram_rdata;
                state_next     = pge_pkg::ST_FIN;
            end

            // Window search: one read a cycle, each compared in the next cycle
            pge_pkg::ST_SRCH,
            pge_pkg::ST_SRCH_TAIL:
            begin
                if (take_best)
                begin
                    found_next = 1'b1;
                    best_next  = ram_rdata;
                    bx_next    = s_x_reg;
                    by_next    = s_y_reg;
                end
                if (state_reg == pge_pkg::ST_SRCH)
                begin
                    ram_re   = 1'b1;
                    s_v_next = 1'b1;
                    s_x_next = cx_reg[XW-1:0];
                    s_y_next = cy_reg[YW-1:0];
                    if (scan_last)
                    begin
                        state_next = pge_pkg::ST_SRCH_TAIL;
                    end
                    else if (cy_reg == yhi_reg)
                    begin
                        cy_next = ylo_reg;
                        cx_next = cx_reg + 1'b1;
                    end
                    else
                    begin
                        cy_next = cy_reg + 1'b1;
                    end
                end
                else
                begin
                    res_status_next = (found_reg || take_best) ? pge_pkg::STAT_OK
                                                               : pge_pkg::STAT_ERR;
                    res_value_next  = take_best ? ram_rdata : best_reg;
                    res_bx_next     = take_best ? 8'(s_x_reg) : 8'(bx_reg);
                    res_by_next     = take_best ? 8'(s_y_reg) : 8'(by_reg);
                    state_next      = pge_pkg::ST_FIN;
                end
            end

            // Hand the result to the output register once it is free
            pge_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    value_next     = res_value_reg;
                    best_x_next    = res_bx_reg;
                    best_y_next    = res_by_reg;
                    state_next     = pge_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pge_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pge_pkg::ST_INIT;
            decay_rate_reg <= '0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            d1_v_reg       <= 1'b0;
            d2_v_reg       <= 1'b0;
            s_v_reg        <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            decay_rate_reg <= decay_rate_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
            d1_v_reg       <= d1_v_next;
            d2_v_reg       <= d2_v_next;
            s_v_reg        <= s_v_next;
            found_reg      <= found_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        r_reg          <= r_next;
        amount_reg     <= amount_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        xlo_reg        <= xlo_next;
        xhi_reg        <= xhi_next;
        ylo_reg        <= ylo_next;
        yhi_reg        <= yhi_next;
        d1_a_reg       <= d1_a_next;
        d2_a_reg       <= d2_a_next;
        dprod_reg      <= dprod_next;
        frac_reg       <= frac_next;
        cell_reg       <= cell_next;
        div_n_reg      <= div_n_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dcnt_reg       <= dcnt_next;
        s_x_reg        <= s_x_next;
        s_y_reg        <= s_y_next;
        best_reg       <= best_next;
        bx_reg         <= bx_next;
        by_reg         <= by_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_bx_reg     <= res_bx_next;
        res_by_reg     <= res_by_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        best_x_reg     <= best_x_next;
        best_y_reg     <= best_y_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign best_x    = best_x_reg;
    assign best_y    = best_y_reg;

`ifndef SYNTH
    // A taken command drops in_ready in the following cycle
    ap_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("command taken while previous one still running");

    // The decay pipeline never writes the cell it is reading
    ap_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("grid read and write hit the same cell");

    // The divider only runs with a nonzero radius
    ap_div_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pge_pkg::ST_DEP_DIV) |-> (r_reg != '0))
        else $error("division by zero radius");

    // A deposit never lowers a cell
    ap_deposit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pge_pkg::ST_DEP_WR) |-> (ram_we && (ram_wdata >= cell_reg)))
        else $error("deposit write lowered a cell");
`endif

endmodule
